@@ rtl/core/centered_window_average_defines.svh @@
// assertion macros shared by the rtl files of the window average block
`ifndef CENTERED_WINDOW_AVERAGE_DEFINES_SVH
`define CENTERED_WINDOW_AVERAGE_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define CWA_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define CWA_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/core/cwa_pkg.sv @@
`default_nettype none

package cwa_pkg;

   // width of a similarity sample and of an average
   localparam int AVG_W = 16;

   // quotient bits resolved per divider cycle
   localparam int STEPS_PER_CYCLE = 4;
   localparam int DIV_CYCLES      = AVG_W / STEPS_PER_CYCLE;

   // entries of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [AVG_W-1:0] average;
      logic             end_of_run;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/cwa_queue.sv @@
`default_nettype none
`include "centered_window_average_defines.svh"

module cwa_queue
   import cwa_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CWA_ASSERT_NOW(a_queue_bound, 1'b1, count_ff <= CW'(QUEUE_DEPTH), "queue count overflow")
   `CWA_ASSERT_NEXT(a_queue_grow, do_push && !do_pop, count_ff == $past(count_ff) + CW'(1), "queue count missed a push")

endmodule

`default_nettype wire

@@ rtl/core/cwa_front.sv @@
`default_nettype none
`include "centered_window_average_defines.svh"

module cwa_front
   import cwa_pkg::*;
#(
   parameter int HALF_WINDOW = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic [AVG_W-1:0]     req_similarity,
   input  wire logic                 req_missing,
   input  wire logic                 req_last_frame,
   output logic                      req_full,
   input  wire logic                 job_full,
   output logic                      job_push,
   output logic [AVG_W+$clog2(2*HALF_WINDOW+1)-1:0] job_sum,
   output logic [$clog2(2*HALF_WINDOW+2)-1:0]       job_count,
   output logic                      job_end
);

   localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
   localparam int IW      = $clog2(WIN_LEN);
   localparam int LW      = IW + 1;
   localparam int CW      = $clog2(WIN_LEN + 1);
   localparam int TW      = AVG_W + IW;
   localparam int RW      = $clog2(HALF_WINDOW + 1);

   logic [AVG_W-1:0] line_ff [WIN_LEN];
   logic [AVG_W-1:0] line_in [WIN_LEN];
   logic [TW-1:0]    total_ff, total_in;
   logic [CW-1:0]    seen_ff, seen_in;
   logic             flushing_ff, flushing_in;
   logic [RW-1:0]    r_ff, r_in;
   logic [IW-1:0]    reach_ff, reach_in;
   logic [TW-1:0]    fsum_ff, fsum_in;

   logic [AVG_W-1:0] sample;
   logic [AVG_W-1:0] drop;
   logic             accept;
   logic [TW-1:0]    acc_total;
   logic [CW-1:0]    acc_seen;
   logic [IW-1:0]    acc_top;
   logic [LW-1:0]    limit;
   logic             trim;

   assign req_full = flushing_ff || job_full;

   always_comb begin
      sample    = req_missing ? '0 : req_similarity;
      accept    = req_push && !req_full;
      drop      = (seen_ff == CW'(WIN_LEN)) ? line_ff[WIN_LEN-1] : '0;
      acc_total = total_ff - TW'(drop) + TW'(sample);
      acc_seen  = (seen_ff == CW'(WIN_LEN)) ? seen_ff : seen_ff + CW'(1);
      acc_top   = IW'(acc_seen - CW'(1));
      limit     = LW'(r_ff) + LW'(HALF_WINDOW);
      trim      = {1'b0, reach_ff} > limit;

      line_in     = line_ff;
      total_in    = total_ff;
      seen_in     = seen_ff;
      flushing_in = flushing_ff;
      r_in        = r_ff;
      reach_in    = reach_ff;
      fsum_in     = fsum_ff;
      job_push    = 1'b0;
      job_sum     = acc_total;
      job_count   = acc_seen;
      job_end     = 1'b0;

      if (flushing_ff) begin
         // shrink the window from its far end, then issue one job per frame
         if (trim) begin
            fsum_in  = fsum_ff - TW'(line_ff[reach_ff]);
            reach_in = reach_ff - IW'(1);
         end else if (!job_full) begin
            job_push  = 1'b1;
            job_sum   = fsum_ff;
            job_count = CW'(reach_ff) + CW'(1);
            job_end   = (r_ff == '0);
            if (r_ff == '0) begin
               flushing_in = 1'b0;
               seen_in     = '0;
               total_in    = '0;
            end else begin
               r_in = r_ff - RW'(1);
            end
         end
      end else if (accept) begin
         for (int i = WIN_LEN - 1; i > 0; i--) begin
            line_in[i] = line_ff[i-1];
         end
         line_in[0] = sample;
         total_in   = acc_total;
         seen_in    = acc_seen;
         if (req_last_frame) begin
            flushing_in = 1'b1;
            fsum_in     = acc_total;
            reach_in    = acc_top;
            r_in        = (acc_top < IW'(HALF_WINDOW)) ? RW'(acc_top) : RW'(HALF_WINDOW);
         end else if (acc_seen >= CW'(HALF_WINDOW + 1)) begin
            job_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         seen_ff     <= '0;
         flushing_ff <= 1'b0;
      end else begin
         total_ff    <= total_in;
         seen_ff     <= seen_in;
         flushing_ff <= flushing_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff  <= line_in;
      r_ff     <= r_in;
      reach_ff <= reach_in;
      fsum_ff  <= fsum_in;
   end

   `CWA_ASSERT_NOW(a_seen_bound, 1'b1, seen_ff <= CW'(WIN_LEN), "frame count past window length")
   `CWA_ASSERT_NOW(a_reach_valid, flushing_ff, CW'(reach_ff) < seen_ff, "flush reaches an unseen frame")

endmodule

`default_nettype wire

@@ rtl/core/cwa_back.sv @@
`default_nettype none
`include "centered_window_average_defines.svh"

module cwa_back
   import cwa_pkg::*;
#(
   parameter int HALF_WINDOW = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 job_empty,
   input  wire logic [AVG_W+$clog2(2*HALF_WINDOW+1)-1:0] job_sum,
   input  wire logic [$clog2(2*HALF_WINDOW+2)-1:0]       job_count,
   input  wire logic                 job_end,
   output logic                      job_pop,
   input  wire logic                 rsp_pop,
   output logic                      rsp_empty,
   output logic [AVG_W-1:0]          rsp_window_average,
   output logic                      rsp_end_of_run
);

   localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
   localparam int IW      = $clog2(WIN_LEN);
   localparam int CW      = $clog2(WIN_LEN + 1);
   localparam int TW      = AVG_W + IW;
   localparam int SW      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   logic             busy_ff, busy_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [AVG_W-1:0] quo_ff, quo_in;
   logic [CW-1:0]    div_ff, div_in;
   logic             end_ff, end_in;
   logic             res_valid_ff, res_valid_in;
   result_type       res_ff, res_in;

   logic [CW:0]      trial;
   logic [CW-1:0]    rem_v;
   logic [AVG_W-1:0] quo_v;
   logic             start, finishing, finish_ok, advance;

   assign rsp_empty          = !res_valid_ff;
   assign rsp_window_average = res_ff.average;
   assign rsp_end_of_run     = res_ff.end_of_run;
   assign job_pop            = start;

   always_comb begin
      // restoring division, a few quotient bits per cycle
      rem_v = rem_ff;
      quo_v = quo_ff;
      trial = '0;
      for (int k = 0; k < STEPS_PER_CYCLE; k++) begin
         trial = {rem_v, quo_v[AVG_W-1]};
         quo_v = {quo_v[AVG_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial    = trial - {1'b0, div_ff};
            quo_v[0] = 1'b1;
         end
         rem_v = trial[CW-1:0];
      end

      start     = !busy_ff && !job_empty;
      finishing = busy_ff && (step_ff == SW'(DIV_CYCLES - 1));
      finish_ok = finishing && (!res_valid_ff || rsp_pop);
      advance   = busy_ff && (!finishing || finish_ok);

      busy_in      = busy_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      end_in       = end_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !rsp_pop;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = CW'(job_sum[TW-1:AVG_W]);
         quo_in  = job_sum[AVG_W-1:0];
         div_in  = job_count;
         end_in  = job_end;
      end else if (advance) begin
         rem_in  = rem_v;
         quo_in  = quo_v;
         step_in = step_ff + SW'(1);
         if (finish_ok) begin
            busy_in            = 1'b0;
            res_valid_in       = 1'b1;
            res_in.average     = quo_v;
            res_in.end_of_run  = end_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      end_ff  <= end_in;
      res_ff  <= res_in;
   end

   `CWA_ASSERT_NOW(a_div_nonzero, busy_ff, div_ff != '0, "divide by zero frames")
   `CWA_ASSERT_NOW(a_rem_below, busy_ff, rem_ff < div_ff, "partial remainder not below divisor")

endmodule

`default_nettype wire

@@ rtl/core/centered_window_average.sv @@
// centered window average: each result goes from the job queue through the divider load
// and the divider steps into the result register; the divider takes no new job until it
// has put its last result into the result register
// a last frame adds window trims from the far end and up to HALF_WINDOW+1 results
// reset: synchronous, active high; clears counts, flags and queue, no clearing pass
`default_nettype none

module centered_window_average
   import cwa_pkg::*;
#(
   parameter int HALF_WINDOW = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire logic [AVG_W-1:0] req_similarity,
   input  wire logic             req_missing,
   input  wire logic             req_last_frame,
   output logic                  req_full,
   input  wire logic             rsp_pop,
   output logic                  rsp_empty,
   output logic [AVG_W-1:0]      rsp_window_average,
   output logic                  rsp_end_of_run
);

   localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
   localparam int IW      = $clog2(WIN_LEN);
   localparam int CW      = $clog2(WIN_LEN + 1);
   localparam int TW      = AVG_W + IW;
   localparam int JW      = TW + CW + 1;

   // job from front to back: window sum, frame count in the window, end of run
   logic          front_push;
   logic [TW-1:0] front_sum;
   logic [CW-1:0] front_count;
   logic          front_end;
   logic          queue_full;
   logic          queue_empty;
   logic          back_pop;
   logic [JW-1:0] queue_out;

   // front: keeps the sample line and running sum, issues one job per result
   cwa_front #(
      .HALF_WINDOW(HALF_WINDOW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_similarity (req_similarity),
      .req_missing    (req_missing),
      .req_last_frame (req_last_frame),
      .req_full       (req_full),
      .job_full       (queue_full),
      .job_push       (front_push),
      .job_sum        (front_sum),
      .job_count      (front_count),
      .job_end        (front_end)
   );

   // short job queue so trimming and dividing overlap
   cwa_queue #(
      .WIDTH(JW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data ({front_sum, front_count, front_end}),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_data  (queue_out),
      .empty     (queue_empty)
   );

   // back: divides sum by count and holds the result until its transfer
   cwa_back #(
      .HALF_WINDOW(HALF_WINDOW)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_empty          (queue_empty),
      .job_sum            (queue_out[JW-1:CW+1]),
      .job_count          (queue_out[CW:1]),
      .job_end            (queue_out[0]),
      .job_pop            (back_pop),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_window_average (rsp_window_average),
      .rsp_end_of_run     (rsp_end_of_run)
   );

endmodule

`default_nettype wire

@@ bench/centered_window_average_test.sv @@
`default_nettype none

module centered_window_average_test
   import cwa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_WINDOW = 5;
   localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;

   // cycles with no transfer on either side before the run is called hung;
   // well above the long receiver hold-off plus a full flush
   localparam int HANG_LIMIT  = 3000;
   // settle time after the last result: queue, divider load, window trim and
   // a flush of HALF_WINDOW+1 divides
   localparam int SETTLE_CYCLES = 64;

   logic             clock;
   logic             reset          = 1'b1;
   logic             req_push       = 1'b0;
   logic [AVG_W-1:0] req_similarity = '0;
   logic             req_missing    = 1'b0;
   logic             req_last_frame = 1'b0;
   logic             req_full;
   logic             rsp_pop        = 1'b0;
   logic             rsp_empty;
   logic [AVG_W-1:0] rsp_window_average;
   logic             rsp_end_of_run;

   // window state of the expected behavior, newest sample first
   logic [AVG_W-1:0] line_samples [WIN_LEN] = '{default: '0};
   int unsigned      window_sum    = 0;
   int unsigned      frames_in_run = 0;

   // averages still owed by the block, oldest first
   result_type       awaited_averages [$];

   int               fault_count     = 0;
   int               frames_sent     = 0;
   bit               steady_rate     = 1'b0;   // no idling on either side
   int               rsp_hold_cycles = 0;      // long receiver hold-off, counted below
   int               pop_gap         = 0;
   int               quiet_cycles    = 0;

   centered_window_average #(
      .HALF_WINDOW(HALF_WINDOW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_similarity(req_similarity),
      .req_missing(req_missing),
      .req_last_frame(req_last_frame),
      .req_full(req_full),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_window_average(rsp_window_average),
      .rsp_end_of_run(rsp_end_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // queue one owed average behind the others
   task automatic owe_average(input result_type item);
      awaited_averages = {awaited_averages, item};
   endtask

   // expected averages for one accepted frame; a frame that is not last gives
   // the average for the frame HALF_WINDOW back once enough frames are in, the
   // last frame flushes every pending frame with a window cut at the tail
   task automatic compute_window_averages(input logic [AVG_W-1:0] similarity,
                                          input logic missing,
                                          input logic last_frame);
      logic [AVG_W-1:0] sample;
      int unsigned      oldest;
      int unsigned      reach;
      int unsigned      span;
      int               k;
      int               j;
      result_type       item;
      sample = missing ? '0 : similarity;
      if (frames_in_run >= WIN_LEN) window_sum -= line_samples[WIN_LEN-1];
      for (k = WIN_LEN - 1; k > 0; k--) line_samples[k] = line_samples[k-1];
      line_samples[0] = sample;
      window_sum += sample;
      if (frames_in_run < WIN_LEN) frames_in_run++;
      if (!last_frame) begin
         if (frames_in_run >= HALF_WINDOW + 1) begin
            item.average    = AVG_W'(window_sum / frames_in_run);
            item.end_of_run = 1'b0;
            owe_average(item);
         end
      end else begin
         oldest = (frames_in_run - 1 < HALF_WINDOW) ? frames_in_run - 1 : HALF_WINDOW;
         // k is how far the result's frame lies behind the newest one
         for (k = oldest; k >= 0; k--) begin
            if (frames_in_run >= k + HALF_WINDOW + 1) reach = k + HALF_WINDOW;
            else reach = frames_in_run - 1;
            span = 0;
            for (j = 0; j <= reach; j++) span += line_samples[j];
            item.average    = AVG_W'(span / (reach + 1));
            item.end_of_run = (k == 0);
            owe_average(item);
         end
         // block goes back to its reset state for the next sequence
         for (k = 0; k < WIN_LEN; k++) line_samples[k] = '0;
         window_sum    = 0;
         frames_in_run = 0;
      end
   endtask

   // offer one frame, maybe after a short gap, and hold it until the transfer
   task automatic push_frame(input logic [AVG_W-1:0] similarity,
                             input logic missing,
                             input logic last_frame);
      if (!steady_rate && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_similarity <= similarity;
      req_missing    <= missing;
      req_last_frame <= last_frame;
      @(posedge clock);
      while (req_full) @(posedge clock);
      // transfer at this edge
      compute_window_averages(similarity, missing, last_frame);
      frames_sent++;
   endtask

   // stop offering and wait for every owed average to come out
   task automatic drain_averages();
      req_push <= 1'b0;
      while (awaited_averages.size() != 0) @(posedge clock);
   endtask

   // mostly uniform, with a share of the extremes and near full scale
   function automatic logic [AVG_W-1:0] random_similarity();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return AVG_W'(65535 - $urandom_range(0, 15));
         default: return AVG_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // mostly short sequences, some that fill the window, a few long ones
   function automatic int random_run_length();
      case ($urandom_range(0, 19))
         0:          return $urandom_range(41, 80);
         1, 2, 3, 4: return $urandom_range(15, 40);
         default:    return $urandom_range(1, 14);
      endcase
   endfunction

   // random length, cut so the frame total does not pass the goal
   function automatic int capped_run_length(input int goal);
      int length;
      length = random_run_length();
      return (length < goal - frames_sent) ? length : goal - frames_sent;
   endfunction

   // random frames; the final one closes the sequence only if asked
   task automatic send_random_run(input int length, input bit close_run);
      int i;
      for (i = 0; i < length; i++) begin
         push_frame(random_similarity(), $urandom_range(0, 7) == 0,
                    close_run && (i == length - 1));
      end
   endtask

   // one-frame sequences: the result is the sample itself, zero when missing
   task automatic test_single_frames();
      push_frame('1, 1'b0, 1'b1);
      push_frame('1, 1'b1, 1'b1);   // missing with a value, value ignored
      push_frame('0, 1'b0, 1'b1);
   endtask

   // sequences too short to emit before their last frame, and the boundary one
   task automatic test_short_runs();
      int i;
      // 1, 2, missing: truncated averages 1, 1, 1 on the cut windows
      push_frame(16'd1, 1'b0, 1'b0);
      push_frame(16'd2, 1'b0, 1'b0);
      push_frame(16'h1234, 1'b1, 1'b1);
      // exactly HALF_WINDOW+1 frames: first result appears on the last input
      for (i = 0; i <= HALF_WINDOW; i++) begin
         push_frame(AVG_W'(16'h8000 + 16'h1111 * i), 1'b0, i == HALF_WINDOW);
      end
   endtask

   // full scale through a saturated window, one missing frame to force truncation
   task automatic test_full_window();
      int i;
      for (i = 0; i < WIN_LEN + 1; i++) begin
         push_frame('1, i == 6, i == WIN_LEN);
      end
   endtask

   task automatic test_random_runs();
      while (frames_sent < 240) send_random_run(capped_run_length(240), 1'b1);
   endtask

   // receiver holds off while the sender keeps offering, so the block backs up
   task automatic test_receiver_hold();
      rsp_hold_cycles = 300;
      send_random_run(40, 1'b1);
      drain_averages();
   endtask

   // sender pauses mid-sequence until every owed average has arrived
   task automatic test_sender_pause();
      int n;
      for (n = 0; n < 3; n++) begin
         send_random_run($urandom_range(1, 12), 1'b0);
         drain_averages();
         send_random_run($urandom_range(1, 12), 1'b1);
      end
   endtask

   // no idling on either side for the last part of the run
   task automatic test_full_rate();
      steady_rate = 1'b1;
      while (frames_sent < 350) send_random_run(capped_run_length(350), 1'b1);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_single_frames();
      test_short_runs();
      test_full_window();
      test_random_runs();
      test_receiver_hold();
      test_sender_pause();
      test_full_rate();
      drain_averages();
      // anything the block still emits now has no expectation and is flagged
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // receiver: random pop gaps, the long hold-off when asked, none at the end
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_pop <= 1'b0;
         rsp_hold_cycles--;
      end else if (pop_gap > 0) begin
         rsp_pop <= 1'b0;
         pop_gap--;
      end else if (!steady_rate && $urandom_range(0, 4) == 0) begin
         rsp_pop <= 1'b0;
         pop_gap = $urandom_range(0, 4);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // compare each result transfer with the oldest owed average
   always @(posedge clock) begin : average_check
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_averages.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual average %0d end %0b",
                     $time, rsp_window_average, rsp_end_of_run);
            fault_count++;
         end else begin
            want = awaited_averages.pop_front();
            if (rsp_window_average !== want.average) begin
               $display("%0t: window_average mismatch, expected %0d, actual %0d",
                        $time, want.average, rsp_window_average);
               fault_count++;
            end
            if (rsp_end_of_run !== want.end_of_run) begin
               $display("%0t: end_of_run mismatch, expected %0b, actual %0b",
                        $time, want.end_of_run, rsp_end_of_run);
               fault_count++;
            end
         end
      end
   end

   // hang watchdog: cycles without a transfer on either side
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d averages owed",
                     $time, quiet_cycles, awaited_averages.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
